FILE: hw/rtl/mfr_pkg.sv
// shared types and constants of the meter frame receiver
`default_nettype none

package mfr_pkg;

   localparam logic [7:0] START_BYTE      = 8'h10;
   localparam logic [7:0] STX_BYTE        = 8'h02;
   localparam logic [7:0] MAX_LENGTH_RST  = 8'd22;
   // header, checksum and tail bytes around the payload
   localparam logic [8:0] FRAME_OVERHEAD  = 9'd7;
   localparam int unsigned FLAG_BYTES     = 4;
   localparam int unsigned FLAG_IDX_W     = $clog2(FLAG_BYTES);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_INVALID  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      QTY_NONE        = 4'd0,
      QTY_VOLTAGE     = 4'd1,
      QTY_CURRENT     = 4'd2,
      QTY_RESISTANCE  = 4'd3,
      QTY_CONTINUITY  = 4'd4,
      QTY_FREQUENCY   = 4'd5,
      QTY_DUTY        = 4'd6,
      QTY_CAPACITANCE = 4'd7,
      QTY_TEMPERATURE = 4'd8,
      QTY_POWER       = 4'd9
   } quantity_type;

   typedef enum logic [3:0] {
      UNIT_NONE       = 4'd0,
      UNIT_VOLT       = 4'd1,
      UNIT_AMPERE     = 4'd2,
      UNIT_OHM        = 4'd3,
      UNIT_HERTZ      = 4'd4,
      UNIT_PERCENT    = 4'd5,
      UNIT_FARAD      = 4'd6,
      UNIT_FAHRENHEIT = 4'd7,
      UNIT_CELSIUS    = 4'd8,
      UNIT_DBM        = 4'd9
   } unit_type;

   typedef struct packed {
      quantity_type quantity;
      unit_type     unit;
      logic         times_thousand;
   } decode_type;

   typedef struct packed {
      status_type   status;
      logic [7:0]   command;
      logic [7:0]   payload_length;
      quantity_type quantity;
      unit_type     unit;
      logic         is_ac;
      logic         is_dc;
      logic         is_diode;
      logic         low_battery;
      logic         times_thousand;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/meter_frame_receiver.sv
// meter link frame receiver top level with result register
//
//   channel   direction  handshake          payload
//   req_      in         valid / ready      rx_byte
//   rsp_      out        valid / ready      status .. times_thousand
//   csr_      in         write enable only  max_frame_length
//
// one request per cycle; a result appears in the cycle after the byte that causes it
// the single result register sets the rate: a request is taken when it is empty
// or being drained in the same cycle
// synchronous reset returns to hunting, max_frame_length to 22, no result held
`default_nettype none

module meter_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_command,
   output logic [7:0]      rsp_payload_length,
   output logic [3:0]      rsp_quantity,
   output logic [3:0]      rsp_unit,
   output logic            rsp_is_ac,
   output logic            rsp_is_dc,
   output logic            rsp_is_diode,
   output logic            rsp_low_battery,
   output logic            rsp_times_thousand,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic [7:0]          max_frame_length_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   mfr_pkg::result_type rsp_data_ff;
   logic                step;
   logic                result_valid;
   mfr_pkg::result_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   mfr_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (req_rx_byte),
      .max_frame_length (max_frame_length_ff),
      .result_valid     (result_valid),
      .result           (result)
   );

   assign rsp_valid_in = step ? result_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_length_ff <= mfr_pkg::MAX_LENGTH_RST;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) max_frame_length_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result_valid) rsp_data_ff <= result;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_command        = rsp_data_ff.command;
   assign rsp_payload_length = rsp_data_ff.payload_length;
   assign rsp_quantity       = rsp_data_ff.quantity;
   assign rsp_unit           = rsp_data_ff.unit;
   assign rsp_is_ac          = rsp_data_ff.is_ac;
   assign rsp_is_dc          = rsp_data_ff.is_dc;
   assign rsp_is_diode       = rsp_data_ff.is_diode;
   assign rsp_low_battery    = rsp_data_ff.low_battery;
   assign rsp_times_thousand = rsp_data_ff.times_thousand;

`ifndef SYNTHESIS
   // a request never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      step |-> (!rsp_valid_ff || rsp_ready))
      else $error("request accepted over a held result");

   // invalid frames carry no decoded measurement
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mfr_pkg::STATUS_INVALID) |->
         (rsp_quantity == mfr_pkg::QTY_NONE && rsp_unit == mfr_pkg::UNIT_NONE &&
          !rsp_times_thousand && !rsp_is_ac && !rsp_is_dc && !rsp_low_battery))
      else $error("invalid frame with decoded fields");

   // the times-1000 mark only comes with a dBm reading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_times_thousand) |->
         (rsp_quantity == mfr_pkg::QTY_POWER && rsp_unit == mfr_pkg::UNIT_DBM))
      else $error("times_thousand without dBm");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mfr_flag_decode.sv
// quantity and unit decode from the flag bytes, last match wins
`default_nettype none

module mfr_flag_decode (
   input  wire logic [7:0]          flag0,
   input  wire logic [7:0]          flag1,
   output mfr_pkg::decode_type      decode
);

   logic ohm;
   logic cap;

   assign ohm = flag0[7];
   assign cap = flag0[3];

   always_comb begin
      decode = '{quantity: mfr_pkg::QTY_NONE, unit: mfr_pkg::UNIT_NONE,
                 times_thousand: 1'b0};
      if (flag0[2]) begin
         decode.quantity = mfr_pkg::QTY_VOLTAGE;
         decode.unit     = mfr_pkg::UNIT_VOLT;
      end
      if (flag1[1]) begin
         decode.quantity = mfr_pkg::QTY_CURRENT;
         decode.unit     = mfr_pkg::UNIT_AMPERE;
      end
      if (ohm) begin
         // beep bit turns resistance into continuity
         decode.quantity = flag1[0] ? mfr_pkg::QTY_CONTINUITY : mfr_pkg::QTY_RESISTANCE;
         decode.unit     = mfr_pkg::UNIT_OHM;
      end
      if (flag1[2]) begin
         decode.quantity = mfr_pkg::QTY_FREQUENCY;
         decode.unit     = mfr_pkg::UNIT_HERTZ;
      end
      if (flag1[3]) begin
         decode.quantity = mfr_pkg::QTY_DUTY;
         decode.unit     = mfr_pkg::UNIT_PERCENT;
      end
      if (flag0[6]) begin
         decode.quantity = mfr_pkg::QTY_TEMPERATURE;
         decode.unit     = mfr_pkg::UNIT_FAHRENHEIT;
      end
      if (flag0[5]) begin
         decode.quantity = mfr_pkg::QTY_TEMPERATURE;
         decode.unit     = mfr_pkg::UNIT_CELSIUS;
      end
      // capacitance overrides the temperature marks
      if (cap) begin
         decode.quantity = mfr_pkg::QTY_CAPACITANCE;
         decode.unit     = mfr_pkg::UNIT_FARAD;
      end
      if (flag1[5] && !ohm) begin
         decode.quantity       = mfr_pkg::QTY_POWER;
         decode.unit           = mfr_pkg::UNIT_DBM;
         decode.times_thousand = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mfr_parser.sv
// frame state machine: header, payload xor, flag capture and result build
`default_nettype none

module mfr_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          max_frame_length,
   output logic                     result_valid,
   output mfr_pkg::result_type      result
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_STX, PH_CMD, PH_LEN, PH_PAYLOAD, PH_CHK, PH_TAIL1, PH_TAIL2
   } phase_type;

   phase_type  phase_ff,          phase_in;
   logic [7:0] byte_count_ff,     byte_count_in;
   logic [7:0] command_ff,        command_in;
   logic [7:0] payload_length_ff, payload_length_in;
   logic [7:0] xor_ff,            xor_in;
   logic [7:0] checksum_ff,       checksum_in;
   logic [7:0] flag_ff [mfr_pkg::FLAG_BYTES];
   logic [7:0] flag_in [mfr_pkg::FLAG_BYTES];

   logic [7:0]          count_next;
   mfr_pkg::decode_type decode;

   mfr_flag_decode u_decode (
      .flag0  (flag_ff[0]),
      .flag1  (flag_ff[1]),
      .decode (decode)
   );

   assign count_next = byte_count_ff + 8'd1;

   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      command_in        = command_ff;
      payload_length_in = payload_length_ff;
      xor_in            = xor_ff;
      checksum_in       = checksum_ff;
      flag_in           = flag_ff;
      result_valid      = 1'b0;
      result            = '0;
      result.status     = mfr_pkg::STATUS_INVALID;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == mfr_pkg::START_BYTE) phase_in = PH_STX;
            end
            PH_STX: begin
               if (rx_byte == mfr_pkg::STX_BYTE) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in     = PH_HUNT;
                  result_valid = 1'b1;
               end
            end
            PH_CMD: begin
               command_in = rx_byte;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               payload_length_in = rx_byte;
               if ({1'b0, rx_byte} + mfr_pkg::FRAME_OVERHEAD > {1'b0, max_frame_length}) begin
                  phase_in              = PH_HUNT;
                  result_valid          = 1'b1;
                  result.command        = command_ff;
                  result.payload_length = rx_byte;
               end else begin
                  xor_in        = '0;
                  byte_count_in = '0;
                  for (int i = 0; i < mfr_pkg::FLAG_BYTES; i++) flag_in[i] = '0;
                  phase_in = (rx_byte == 8'd0) ? PH_CHK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               xor_in = xor_ff ^ rx_byte;
               if (byte_count_ff < 8'(mfr_pkg::FLAG_BYTES))
                  flag_in[byte_count_ff[mfr_pkg::FLAG_IDX_W-1:0]] = rx_byte;
               byte_count_in = count_next;
               if (count_next == payload_length_ff) phase_in = PH_CHK;
            end
            PH_CHK: begin
               checksum_in = rx_byte;
               phase_in    = PH_TAIL1;
            end
            PH_TAIL1: begin
               phase_in = PH_TAIL2;
            end
            PH_TAIL2: begin
               phase_in              = PH_HUNT;
               result_valid          = 1'b1;
               result.status         = (checksum_ff == xor_ff) ? mfr_pkg::STATUS_OK
                                                               : mfr_pkg::STATUS_MISMATCH;
               result.command        = command_ff;
               result.payload_length = payload_length_ff;
               result.quantity       = decode.quantity;
               result.unit           = decode.unit;
               result.is_ac          = flag_ff[0][0];
               result.is_dc          = flag_ff[0][1];
               result.is_diode       = flag_ff[0][4];
               result.low_battery    = flag_ff[3][7];
               result.times_thousand = decode.times_thousand;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         byte_count_ff     <= '0;
         command_ff        <= '0;
         payload_length_ff <= '0;
         xor_ff            <= '0;
         checksum_ff       <= '0;
         for (int i = 0; i < mfr_pkg::FLAG_BYTES; i++) flag_ff[i] <= '0;
      end else begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         command_ff        <= command_in;
         payload_length_ff <= payload_length_in;
         xor_ff            <= xor_in;
         checksum_ff       <= checksum_in;
         flag_ff           <= flag_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/meter_frame_receiver_tb.sv
// testbench for the meter frame receiver: directed and random frames, each report checked field by field
`timescale 1ns / 1ps

module meter_frame_receiver_tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int PRESSURE_HOLD = 300;

   typedef logic [7:0] octet_q [$];

   typedef enum logic [2:0] {
      SEEK_START,
      SEEK_STX,
      GET_COMMAND,
      GET_LENGTH,
      GET_PAYLOAD,
      GET_CHECKSUM,
      GET_TAIL1,
      GET_TAIL2
   } rx_phase_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic [7:0] rsp_command;
   logic [7:0] rsp_payload_length;
   logic [3:0] rsp_quantity;
   logic [3:0] rsp_unit;
   logic       rsp_is_ac;
   logic       rsp_is_dc;
   logic       rsp_is_diode;
   logic       rsp_low_battery;
   logic       rsp_times_thousand;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   // receive state mirrored from the link frame rules
   rx_phase_type rx_phase;
   logic [7:0]   frame_limit;
   logic [7:0]   pay_count;
   logic [7:0]   cur_command;
   logic [7:0]   cur_length;
   logic [7:0]   pay_xor;
   logic [7:0]   got_checksum;
   logic [7:0]   flags [mfr_pkg::FLAG_BYTES];

   mfr_pkg::result_type awaited_reports [$];
   int         failures;
   int         bytes_sent;
   bit         sender_idles;
   bit         receiver_stalls;
   int         hold_cycles;
   int         quiet_cycles;

   meter_frame_receiver dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_quantity       (rsp_quantity),
      .rsp_unit           (rsp_unit),
      .rsp_is_ac          (rsp_is_ac),
      .rsp_is_dc          (rsp_is_dc),
      .rsp_is_diode       (rsp_is_diode),
      .rsp_low_battery    (rsp_low_battery),
      .rsp_times_thousand (rsp_times_thousand),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // expected report of a finished frame; for quantity and unit, later flags override earlier ones
   function automatic mfr_pkg::result_type decode_frame();
      mfr_pkg::result_type r;
      logic       ohm;
      logic       cap;
      r = '0;
      ohm = flags[0][7];
      cap = flags[0][3];
      if (flags[0][2]) begin
         r.quantity = mfr_pkg::QTY_VOLTAGE;
         r.unit = mfr_pkg::UNIT_VOLT;
      end
      if (flags[1][1]) begin
         r.quantity = mfr_pkg::QTY_CURRENT;
         r.unit = mfr_pkg::UNIT_AMPERE;
      end
      if (ohm) begin
         r.quantity = flags[1][0] ? mfr_pkg::QTY_CONTINUITY : mfr_pkg::QTY_RESISTANCE;
         r.unit = mfr_pkg::UNIT_OHM;
      end
      if (flags[1][2]) begin
         r.quantity = mfr_pkg::QTY_FREQUENCY;
         r.unit = mfr_pkg::UNIT_HERTZ;
      end
      if (flags[1][3]) begin
         r.quantity = mfr_pkg::QTY_DUTY;
         r.unit = mfr_pkg::UNIT_PERCENT;
      end
      if (cap) begin
         r.quantity = mfr_pkg::QTY_CAPACITANCE;
         r.unit = mfr_pkg::UNIT_FARAD;
      end
      if (flags[0][6]) begin
         r.quantity = mfr_pkg::QTY_TEMPERATURE;
         r.unit = mfr_pkg::UNIT_FAHRENHEIT;
      end
      if (flags[0][5]) begin
         r.quantity = mfr_pkg::QTY_TEMPERATURE;
         r.unit = mfr_pkg::UNIT_CELSIUS;
      end
      if (cap) begin
         r.quantity = mfr_pkg::QTY_CAPACITANCE;
         r.unit = mfr_pkg::UNIT_FARAD;
      end
      if (flags[1][5] && !ohm) begin
         r.quantity = mfr_pkg::QTY_POWER;
         r.unit = mfr_pkg::UNIT_DBM;
         r.times_thousand = 1'b1;
      end
      r.status = (got_checksum == pay_xor) ? mfr_pkg::STATUS_OK
                                           : mfr_pkg::STATUS_MISMATCH;
      r.command = cur_command;
      r.payload_length = cur_length;
      r.is_ac = flags[0][0];
      r.is_dc = flags[0][1];
      r.is_diode = flags[0][4];
      r.low_battery = flags[3][7];
      return r;
   endfunction

   function automatic void clear_receive_state();
      rx_phase = SEEK_START;
      frame_limit = mfr_pkg::MAX_LENGTH_RST;
      pay_count = '0;
      cur_command = '0;
      cur_length = '0;
      pay_xor = '0;
      got_checksum = '0;
      foreach (flags[i]) flags[i] = '0;
   endfunction

   function automatic bit too_long(input logic [7:0] len);
      return ({1'b0, len} + mfr_pkg::FRAME_OVERHEAD) > {1'b0, frame_limit};
   endfunction

   function automatic void decode_rx_byte(input logic [7:0] b);
      mfr_pkg::result_type r;
      r = '0;
      case (rx_phase)
         SEEK_START: begin
            if (b == mfr_pkg::START_BYTE) rx_phase = SEEK_STX;
         end
         SEEK_STX: begin
            if (b == mfr_pkg::STX_BYTE) begin
               rx_phase = GET_COMMAND;
            end else begin
               rx_phase = SEEK_START;
               r.status = mfr_pkg::STATUS_INVALID;
               awaited_reports.push_back(r);
            end
         end
         GET_COMMAND: begin
            cur_command = b;
            rx_phase = GET_LENGTH;
         end
         GET_LENGTH: begin
            cur_length = b;
            if (too_long(b)) begin
               rx_phase = SEEK_START;
               r.status = mfr_pkg::STATUS_INVALID;
               r.command = cur_command;
               r.payload_length = b;
               awaited_reports.push_back(r);
            end else begin
               pay_xor = '0;
               pay_count = '0;
               foreach (flags[i]) flags[i] = '0;
               if (b == 8'd0) rx_phase = GET_CHECKSUM;
               else rx_phase = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            pay_xor ^= b;
            if (pay_count < mfr_pkg::FLAG_BYTES)
               flags[pay_count[mfr_pkg::FLAG_IDX_W-1:0]] = b;
            pay_count = pay_count + 8'd1;
            if (pay_count == cur_length) rx_phase = GET_CHECKSUM;
         end
         GET_CHECKSUM: begin
            got_checksum = b;
            rx_phase = GET_TAIL1;
         end
         GET_TAIL1: begin
            rx_phase = GET_TAIL2;
         end
         default: begin
            rx_phase = SEEK_START;
            awaited_reports.push_back(decode_frame());
         end
      endcase
   endfunction

   // called at a rising edge; returns at the edge that takes the request
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input octet_q payload, input bit corrupt);
      logic [7:0] sum;
      sum = '0;
      send_byte(mfr_pkg::START_BYTE);
      send_byte(mfr_pkg::STX_BYTE);
      send_byte(cmd);
      send_byte(len);
      if (too_long(len)) return;
      foreach (payload[i]) begin
         send_byte(payload[i]);
         sum ^= payload[i];
      end
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
   endtask

   // sparse flag bytes so that low priority decodes also show up
   function automatic logic [7:0] pick_flag_byte();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(0, 255));
         1: return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd1 << $urandom_range(0, 7);
         default: return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
      endcase
   endfunction

   function automatic octet_q random_payload(input int len);
      octet_q q;
      for (int i = 0; i < len; i++) begin
         if (i < mfr_pkg::FLAG_BYTES) q.push_back(pick_flag_byte());
         else q.push_back(8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_reports.size() != 0);
      // a byte without a report may still be in the pipeline
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [7:0] limit);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_limit = limit;
   endtask

   task automatic run_random_traffic(input int n_bytes);
      int         stop_at;
      int         kind;
      int         room;
      logic [7:0] len;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         room = int'(frame_limit) - 7;
         if (kind < 75 || (kind >= 93 && frame_limit == 8'd255)) begin
            if (room <= 0) len = 8'd0;
            else if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(0, room));
            else len = 8'($urandom_range(0, (room < 12) ? room : 12));
            send_frame(8'($urandom_range(0, 255)), len, random_payload(len),
                       $urandom_range(0, 3) == 0);
         end else if (kind < 85) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (kind < 93) begin
            send_byte(mfr_pkg::START_BYTE);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            len = 8'($urandom_range(int'(frame_limit) - 6, 255));
            send_frame(8'($urandom_range(0, 255)), len, random_payload(0), 1'b0);
         end
      end
   endtask

   task automatic test_directed_frames();
      octet_q none;
      octet_q all_ones;
      all_ones = '{8'hFF, 8'hFF};
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'hFF, 8'd0, none, 1'b0);
      // second start byte where the stx belongs is consumed, the stx after is noise
      send_byte(mfr_pkg::START_BYTE);
      send_byte(mfr_pkg::START_BYTE);
      send_byte(mfr_pkg::STX_BYTE);
      send_frame(8'h00, 8'd16, none, 1'b0);
      // short payload, bad checksum, every bit of the first two flag bytes set
      send_frame(8'h5A, 8'd2, all_ones, 1'b1);
      wait_idle();
   endtask

   task automatic test_frame_limit_settings();
      write_frame_limit(8'd7);
      send_frame(8'h11, 8'd0, random_payload(0), 1'b0);
      send_frame(8'h22, 8'd1, random_payload(1), 1'b0);
      write_frame_limit(8'd255);
      send_frame(8'hA5, 8'd248, random_payload(248), 1'b0);
      send_frame(8'h5A, 8'd249, random_payload(0), 1'b0);
      write_frame_limit(mfr_pkg::MAX_LENGTH_RST);
      send_frame(8'h33, 8'd15, random_payload(15), 1'b0);
      // new limit lands between command and length byte
      send_byte(mfr_pkg::START_BYTE);
      send_byte(mfr_pkg::STX_BYTE);
      send_byte(8'hC3);
      write_frame_limit(8'd8);
      send_byte(8'd1);
      send_byte(8'h81);
      send_byte(8'h81);
      send_byte(8'h00);
      send_byte(8'h00);
      send_frame(8'h44, 8'd15, random_payload(0), 1'b0);
      write_frame_limit(8'd128);
      send_frame(8'h66, 8'd121, random_payload(121), 1'b1);
      send_frame(8'h77, 8'd122, random_payload(0), 1'b0);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      sender_idles = 1'b0;
      hold_cycles = PRESSURE_HOLD;
      repeat (40) begin
         send_byte(mfr_pkg::START_BYTE);
         send_byte(8'h00);
      end
      sender_idles = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_frames();
      write_frame_limit(mfr_pkg::MAX_LENGTH_RST);
      run_random_traffic(300);
      write_frame_limit(8'd7);
      run_random_traffic(300);
      write_frame_limit(8'd255);
      run_random_traffic(300);
      write_frame_limit(8'($urandom_range(8, 254)));
      run_random_traffic(300);
   endtask

   task automatic test_quiet_stream();
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      write_frame_limit(8'($urandom_range(20, 60)));
      run_random_traffic(300);
   endtask

   initial begin : receiver
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      mfr_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: report with none outstanding, expected nothing, actual status %0d",
                     $time, rsp_status);
            failures++;
         end else begin
            want = awaited_reports.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("command", want.command, rsp_command);
            compare_field("payload_length", want.payload_length, rsp_payload_length);
            compare_field("quantity", want.quantity, rsp_quantity);
            compare_field("unit", want.unit, rsp_unit);
            compare_field("is_ac", want.is_ac, rsp_is_ac);
            compare_field("is_dc", want.is_dc, rsp_is_dc);
            compare_field("is_diode", want.is_diode, rsp_is_diode);
            compare_field("low_battery", want.low_battery, rsp_low_battery);
            compare_field("times_thousand", want.times_thousand, rsp_times_thousand);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or report moved for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      hold_cycles = 0;
      quiet_cycles = 0;
      failures = 0;
      bytes_sent = 0;
      clear_receive_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_frame_limit_settings();
      test_output_backpressure();
      test_random_frames();
      test_quiet_stream();
      wait_idle();
      repeat (8) @(posedge clock);
      failures += awaited_reports.size();
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_flag_decode.sv
hw/rtl/mfr_parser.sv
hw/rtl/meter_frame_receiver.sv
tb/sv/meter_frame_receiver_tb.sv
